[hw/rtl/mvcc_pkg.sv]
// Shared types and constants for the snapshot visibility checker.
// Used by every module of the block and by its port checker.
package mvcc_pkg;

  localparam int ActiveEntriesDef = 16;
  localparam int QueueDepth       = 2;
  localparam int StampW           = 64;
  localparam int IdW              = 64;
  localparam int CfgIdxW          = 1;
  localparam int InDataW          = 4 * 64;
  localparam int InUserW          = 8;
  localparam int OutDataW         = 8;

  typedef enum logic [1:0] {
    REQ_CLEAR   = 2'd0,
    REQ_ADD     = 2'd1,
    REQ_VERSION = 2'd2,
    REQ_TXN     = 2'd3
  } req_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SNAP_STAMP = 1'b0,
    CFG_ISO_MODE   = 1'b1
  } cfg_idx_t;

  // Classified request passed from the front to the back.
  typedef struct packed {
    req_t           kind;
    logic [IdW-1:0] id;
    logic           strict;    // active set hides ids
    logic           base_vis;  // visibility before the active-set lookup
  } item_t;

endpackage

[hw/rtl/mvcc_front.sv]
// Front stage: accepts request items and classifies them against the snapshot.
// Depends on mvcc_pkg; feeds mvcc_queue.
module mvcc_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                req_type,
  input  logic [mvcc_pkg::IdW-1:0]    txn_ident,
  input  logic [mvcc_pkg::StampW-1:0] create_stamp,
  input  logic [mvcc_pkg::IdW-1:0]    remove_txn,
  input  logic [mvcc_pkg::StampW-1:0] remove_stamp,
  input  logic [mvcc_pkg::StampW-1:0] snap_stamp,
  input  logic                      iso_mode,
  input  logic                      q_full,
  output logic                      push_valid,
  output mvcc_pkg::item_t           push_item
);

  logic            fv;
  mvcc_pkg::item_t f_item;
  mvcc_pkg::item_t item_next;
  logic            cs_ok;
  logic            removed;

  assign in_ready   = !fv || !q_full;
  assign push_valid = fv;
  assign push_item  = f_item;

  always_comb begin
    cs_ok   = create_stamp <= snap_stamp;
    removed = (remove_stamp != '0) && (remove_stamp <= snap_stamp) &&
              (!iso_mode || (remove_txn != '0));
    item_next.kind   = mvcc_pkg::req_t'(req_type);
    item_next.id     = txn_ident;
    item_next.strict = iso_mode;
    case (mvcc_pkg::req_t'(req_type))
      mvcc_pkg::REQ_VERSION: item_next.base_vis = cs_ok && !removed;
      mvcc_pkg::REQ_TXN:     item_next.base_vis = cs_ok && (create_stamp != '0);
      default:               item_next.base_vis = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (in_ready) begin
      fv <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      f_item <= item_next;
    end
  end

endmodule

[hw/rtl/mvcc_queue.sv]
// Short queue of classified items between front and back.
// Depends on mvcc_pkg for the item type and depth.
module mvcc_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  mvcc_pkg::item_t push_item,
  output logic            full,
  output logic            head_valid,
  output mvcc_pkg::item_t head_item,
  input  logic            pop
);

  localparam int PtrW = (mvcc_pkg::QueueDepth > 1) ? $clog2(mvcc_pkg::QueueDepth) : 1;
  localparam int CntW = $clog2(mvcc_pkg::QueueDepth + 1);

  mvcc_pkg::item_t slots [mvcc_pkg::QueueDepth];
  logic [PtrW-1:0] wp;
  logic [PtrW-1:0] rp;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign full       = count == CntW'(mvcc_pkg::QueueDepth);
  assign head_valid = count != '0;
  assign head_item  = slots[rp];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wp <= (wp == PtrW'(mvcc_pkg::QueueDepth - 1)) ? '0 : wp + PtrW'(1);
      end
      if (do_pop) begin
        rp <= (rp == PtrW'(mvcc_pkg::QueueDepth - 1)) ? '0 : rp + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CntW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wp] <= push_item;
    end
  end

endmodule

[hw/rtl/mvcc_back.sv]
// Back stage: active-set table, lookup and update, and the result register.
// Depends on mvcc_pkg; drains mvcc_queue.
module mvcc_back #(
  parameter int ACTIVE_ENTRIES = mvcc_pkg::ActiveEntriesDef
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  mvcc_pkg::item_t head_item,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            visible,
  output logic            status
);

  localparam int IdxW = (ACTIVE_ENTRIES > 1) ? $clog2(ACTIVE_ENTRIES) : 1;

  logic [mvcc_pkg::IdW-1:0] ids [ACTIVE_ENTRIES];
  logic [ACTIVE_ENTRIES-1:0] valid;
  logic                      hit;
  logic                      any_free;
  logic [IdxW-1:0]           free_idx;
  logic                      vis_next;
  logic                      stat_next;
  logic                      do_store;

  assign pop = head_valid && (!out_valid || out_ready);

  // Parallel compare over the table; lowest free slot wins.
  always_comb begin
    hit      = 1'b0;
    any_free = 1'b0;
    free_idx = '0;
    for (int i = 0; i < ACTIVE_ENTRIES; i++) begin
      if (valid[i] && (ids[i] == head_item.id)) begin
        hit = 1'b1;
      end
    end
    for (int i = ACTIVE_ENTRIES - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        any_free = 1'b1;
        free_idx = IdxW'(i);
      end
    end
  end

  always_comb begin
    vis_next  = 1'b0;
    stat_next = 1'b0;
    do_store  = 1'b0;
    case (head_item.kind)
      mvcc_pkg::REQ_ADD: begin
        do_store  = !hit && any_free;
        stat_next = !hit && !any_free;
      end
      mvcc_pkg::REQ_VERSION,
      mvcc_pkg::REQ_TXN: vis_next = head_item.base_vis && !(head_item.strict && hit);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        out_valid <= 1'b1;
        if (head_item.kind == mvcc_pkg::REQ_CLEAR) begin
          valid <= '0;
        end else if (do_store) begin
          valid[free_idx] <= 1'b1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && do_store) begin
      ids[free_idx] <= head_item.id;
    end
    if (pop) begin
      visible <= vis_next;
      status  <= stat_next;
    end
  end

endmodule

[hw/rtl/mvcc_snapshot_visibility_check.sv]
// Top level of the MVCC snapshot visibility checker.
// Depends on mvcc_pkg, mvcc_front, mvcc_queue and mvcc_back.
//
//   channel  dir  handshake            payload
//   s_*      in   s_tvalid/s_tready    tdata: txn_ident, create_stamp, remove_txn,
//                                      remove_stamp; tuser: req_type
//   m_*      out  m_tvalid/m_tready    tdata: visible, status, zero pad
//   cfg_*    in   cfg_valid/cfg_ready  cfg_index, cfg_data (always ready)
//
// Flow: one item per clock sustained while m_tready holds high; a result passes
// the front register, a queue slot and the result register in turn. The table
// lookup and update in the back stage set that rate: one request per clock there.
// Reset: control state and the active-set valid bits clear at once; snap_stamp
// goes to 0 and iso_mode to 1. There is no clearing pass.
// Stalls: the two-entry queue lets the front keep taking items while the
// result register waits on m_tready.
module mvcc_snapshot_visibility_check #(
  parameter int ACTIVE_ENTRIES = mvcc_pkg::ActiveEntriesDef
) (
  input  logic                          clk,
  input  logic                          rst,
  // request items
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // [63:0] txn_ident, [127:64] create_stamp, [191:128] remove_txn,
  // [255:192] remove_stamp
  input  logic [mvcc_pkg::InDataW-1:0]  s_tdata,
  // [1:0] req_type, [7:2] zero
  input  logic [mvcc_pkg::InUserW-1:0]  s_tuser,
  // result items
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [0] visible, [1] status, [7:2] zero
  output logic [mvcc_pkg::OutDataW-1:0] m_tdata,
  // configuration writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mvcc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [63:0]                   cfg_data
);

  logic [mvcc_pkg::StampW-1:0] snap_stamp;
  logic                        iso_mode;
  logic                        q_full;
  logic                        push_valid;
  mvcc_pkg::item_t             push_item;
  logic                        head_valid;
  mvcc_pkg::item_t             head_item;
  logic                        pop;
  logic                        visible;
  logic                        status;

  // Configuration registers; writes are to land only while the block is idle (not enforced here).
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_stamp <= '0;
      iso_mode   <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (mvcc_pkg::cfg_idx_t'(cfg_index))
        mvcc_pkg::CFG_SNAP_STAMP: snap_stamp <= cfg_data;
        mvcc_pkg::CFG_ISO_MODE:   iso_mode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Front: classify stamps against the snapshot.
  mvcc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .req_type     (s_tuser[1:0]),
    .txn_ident    (s_tdata[63:0]),
    .create_stamp (s_tdata[127:64]),
    .remove_txn   (s_tdata[191:128]),
    .remove_stamp (s_tdata[255:192]),
    .snap_stamp   (snap_stamp),
    .iso_mode     (iso_mode),
    .q_full       (q_full),
    .push_valid   (push_valid),
    .push_item    (push_item)
  );

  // Decouple front and back.
  mvcc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push_valid),
    .push_item  (push_item),
    .full       (q_full),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop)
  );

  // Back: active-set lookup and update, hold the result until taken.
  mvcc_back #(
    .ACTIVE_ENTRIES (ACTIVE_ENTRIES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .visible    (visible),
    .status     (status)
  );

  assign m_tdata = {(mvcc_pkg::OutDataW - 2)'(0), status, visible};

endmodule

[hw/rtl/mvcc_checker.sv]
// Port checker for the snapshot visibility checker, bound to the top level.
// Depends on mvcc_pkg and mvcc_snapshot_visibility_check.
module mvcc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [mvcc_pkg::OutDataW-1:0] m_tdata
);

  // A result waiting on the sink stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // A stalled result keeps its bits.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result changed while stalled");

  // A refused add never reports visible.
  a_vis_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
    else $error("visible and status both set");

  // Nothing comes out the clock after reset.
  a_reset_quiet: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !m_tvalid)
    else $error("result right after reset");

endmodule

bind mvcc_snapshot_visibility_check mvcc_checker u_mvcc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

[dv/mvcc_visibility_checker.sv]
// Port checker for the snapshot visibility block: predicts each answer and compares.
// Depends on mvcc_pkg; watches the request, result and configuration channels.
module mvcc_visibility_checker
  import mvcc_pkg::*;
#(
  parameter int ACTIVE_ENTRIES = ActiveEntriesDef
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  input  logic                s_tready,
  // [63:0] txn_ident, [127:64] create_stamp, [191:128] remove_txn,
  // [255:192] remove_stamp
  input  logic [InDataW-1:0]  s_tdata,
  // [1:0] req_type, [7:2] zero
  input  logic [InUserW-1:0]  s_tuser,
  input  logic                m_tvalid,
  input  logic                m_tready,
  // [0] visible, [1] status, [7:2] zero
  input  logic [OutDataW-1:0] m_tdata,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [63:0]         cfg_data,
  output int                  fail_count,
  output int                  answers_open
);

  typedef struct packed {
    logic visible;
    logic status;
  } answer_t;

  logic [StampW-1:0] snap;
  logic              iso_strict;
  logic [IdW-1:0]    ids  [ACTIVE_ENTRIES];
  logic              live [ACTIVE_ENTRIES];
  answer_t           answers_due [$];
  int                mismatches = 0;

  assign fail_count = mismatches;

  function automatic logic id_active(logic [IdW-1:0] id);
    for (int i = 0; i < ACTIVE_ENTRIES; i++) begin
      if (live[i] && ids[i] == id) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Update the active table and work out the answer for one request.
  function automatic answer_t apply_request(req_t kind, logic [IdW-1:0] id,
                                            logic [StampW-1:0] cs, logic [IdW-1:0] rt,
                                            logic [StampW-1:0] rs);
    answer_t ans;
    logic    hidden_by_set;
    logic    removed;
    int      slot;
    ans = '0;
    hidden_by_set = iso_strict && id_active(id);
    case (kind)
      REQ_CLEAR: begin
        foreach (live[i]) live[i] = 1'b0;
      end
      REQ_ADD: begin
        if (!id_active(id)) begin
          slot = -1;
          for (int i = ACTIVE_ENTRIES - 1; i >= 0; i--) begin
            if (!live[i]) slot = i;
          end
          if (slot < 0) begin
            ans.status = 1'b1;
          end else begin
            ids[slot]  = id;
            live[slot] = 1'b1;
          end
        end
      end
      REQ_VERSION: begin
        removed = (rs != '0) && (rs <= snap) && (!iso_strict || rt != '0);
        ans.visible = !hidden_by_set && (cs <= snap) && !removed;
      end
      default: begin
        ans.visible = !hidden_by_set && (cs != '0) && (cs <= snap);
      end
    endcase
    return ans;
  endfunction

  task automatic report_mismatch(string what, logic [OutDataW-1:0] got, answer_t want);
    $display("mismatch at %0t: %s (tdata %h, want visible %b status %b)",
             $time, what, got, want.visible, want.status);
    mismatches++;
  endtask

  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      snap = '0;
      iso_strict = 1'b1;
      foreach (live[i]) live[i] = 1'b0;
      answers_due.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (answers_due.size() == 0) begin
          report_mismatch("result with no request waiting", m_tdata, '0);
        end else begin
          want = answers_due.pop_front();
          if (m_tdata[0] !== want.visible) report_mismatch("visible", m_tdata, want);
          if (m_tdata[1] !== want.status) report_mismatch("status", m_tdata, want);
          if (m_tdata[OutDataW-1:2] !== '0) report_mismatch("pad bits", m_tdata, want);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_SNAP_STAMP: snap = cfg_data;
          CFG_ISO_MODE:   iso_strict = cfg_data[0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        answers_due = {answers_due, apply_request(req_t'(s_tuser[1:0]), s_tdata[63:0],
                                                  s_tdata[127:64], s_tdata[191:128],
                                                  s_tdata[255:192])};
      end
    end
    answers_open <= answers_due.size();
  end

endmodule

[dv/tb_mvcc_snapshot_visibility_check.sv]
// Testbench top for the snapshot visibility block: drives requests and settings.
// Depends on mvcc_pkg, the block itself and mvcc_visibility_checker.
module tb_mvcc_snapshot_visibility_check;
  import mvcc_pkg::*;

  localparam int CycleLimit  = 400000;
  localparam int DrainCycles = 8;    // result passes front register, queue slot and result register
  localparam int HoldCycles  = 300;  // long receiver hold-off
  localparam int PhaseItems  = 56;
  localparam int IdPool      = 24;   // small id pool so the table hits and fills

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                s_tvalid  = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata   = '0;
  logic [InUserW-1:0]  s_tuser   = '0;
  logic                m_tvalid;
  logic                m_tready  = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [63:0]         cfg_data  = '0;

  int          fail_count;
  int          answers_open;
  int          snd_idle  = 0;   // percent of cycles the sender idles
  int          rcv_idle  = 0;   // percent of cycles the receiver stalls
  int          hold_req  = 0;   // bumped by the stimulus to request a hold-off
  int          hold_done = 0;   // caught up by the receiver when a hold-off ends
  logic [63:0] snap_now  = '0;  // current snapshot, used to aim stamps at its edges

  mvcc_snapshot_visibility_check uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  mvcc_visibility_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .answers_open (answers_open)
  );

  always #1 clk = ~clk;

  // Receiver: stall at random, or hold off for a long stretch when asked.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req != hold_done) begin
        m_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_done = hold_req;
      end else begin
        m_tready <= ($urandom_range(99) >= rcv_idle);
      end
    end
  end

  // Watchdog: count cycles and stop a run that hangs.
  initial begin
    int cyc;
    cyc = 0;
    while (cyc < CycleLimit) begin
      @(posedge clk);
      cyc++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Aim stamps at zero, the snapshot and its neighbors, the top value, or anywhere.
  function automatic logic [63:0] pick_stamp();
    case ($urandom_range(7))
      0:       return '0;
      1:       return snap_now;
      2:       return snap_now - 64'd1;
      3:       return snap_now + 64'd1;
      4:       return '1;
      5:       return snap_now - 64'($urandom_range(1000));
      6:       return snap_now + 64'($urandom_range(1000));
      default: return rand64();
    endcase
  endfunction

  // Mostly ids from the small pool; now and then the extremes or a wild id.
  function automatic logic [63:0] pick_id();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return rand64();
      default: return 64'($urandom_range(1, IdPool));
    endcase
  endfunction

  // Offer one request item and hold it until the block takes it.
  task automatic send_request(req_t kind, logic [63:0] id, logic [63:0] cs,
                              logic [63:0] rt, logic [63:0] rs);
    while ($urandom_range(99) < snd_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {rs, rt, cs, id};
    s_tuser  <= {{(InUserW - 2){1'b0}}, kind};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Drop valid and wait until every answer has come back.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (answers_open != 0) @(posedge clk);
  endtask

  // Write both registers back to back; only called while the block is idle.
  task automatic configure(logic [63:0] snap_v, logic [63:0] iso_v);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_SNAP_STAMP;
    cfg_data  <= snap_v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= CFG_ISO_MODE;
    cfg_data  <= iso_v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    snap_now = snap_v;
  endtask

  // Bursts of adds followed by checks on ids from the same pool, with the odd clear.
  task automatic random_phase();
    int n;
    n = 0;
    while (n < PhaseItems) begin
      if ($urandom_range(9) == 0) begin
        send_request(REQ_CLEAR, rand64(), rand64(), rand64(), rand64());
        n++;
      end
      repeat ($urandom_range(1, 6)) begin
        send_request(REQ_ADD, pick_id(), rand64(), rand64(), rand64());
        n++;
      end
      repeat ($urandom_range(2, 10)) begin
        if ($urandom_range(1) == 0) begin
          send_request(REQ_VERSION, pick_id(), pick_stamp(),
                       ($urandom_range(2) == 0) ? 64'd0 : pick_id(), pick_stamp());
        end else begin
          send_request(REQ_TXN, pick_id(), pick_stamp(), rand64(), rand64());
        end
        n++;
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: snapshot 0, strict mode. Uncommitted txn, then an all-zero version.
    send_request(REQ_TXN, 64'd5, 64'd0, '1, '1);
    send_request(REQ_VERSION, '0, '0, '0, '0);
    drain();

    configure(64'd1000, 64'd1);
    // Zero and all-ones ids into the set, then a duplicate add.
    send_request(REQ_ADD, '0, '1, '1, '1);
    send_request(REQ_ADD, '1, '0, '0, '0);
    send_request(REQ_ADD, '1, '0, '0, '0);
    // Active ids are hidden in strict mode.
    send_request(REQ_VERSION, '1, 64'd10, 64'd0, 64'd0);
    send_request(REQ_TXN, '0, 64'd1, 64'd0, 64'd0);
    // Creation stamp on and past the snapshot.
    send_request(REQ_VERSION, 64'd7, 64'd1000, 64'd0, 64'd0);
    send_request(REQ_VERSION, 64'd7, '1, 64'd0, 64'd0);
    // Deletion needs a deleting id in strict mode.
    send_request(REQ_VERSION, 64'd7, 64'd5, 64'd0, 64'd1000);
    send_request(REQ_VERSION, 64'd7, 64'd5, '1, 64'd1000);
    send_request(REQ_VERSION, 64'd7, 64'd5, 64'd9, '1);
    // Commit on and far past the snapshot.
    send_request(REQ_TXN, 64'd7, 64'd1000, 64'd0, 64'd0);
    send_request(REQ_TXN, 64'd7, '1, 64'd0, 64'd0);
    // Fill the table, then try one more new id against the full table.
    for (int i = 2; i < 16; i++) send_request(REQ_ADD, 64'(i), '0, '0, '0);
    send_request(REQ_ADD, 64'd99, '0, '0, '0);
    send_request(REQ_VERSION, 64'd15, 64'd5, 64'd0, 64'd0);
    drain();

    // Read committed: the active set is ignored and any deletion stamp counts.
    configure(64'd1000, 64'd0);
    send_request(REQ_VERSION, '1, 64'd10, 64'd0, 64'd0);
    send_request(REQ_VERSION, 64'd7, 64'd5, 64'd0, 64'd1000);
    send_request(REQ_TXN, '0, 64'd0, '1, '1);
    send_request(REQ_TXN, '1, 64'd1000, 64'd0, 64'd0);
    send_request(REQ_CLEAR, '1, '1, '1, '1);
    send_request(REQ_ADD, 64'd99, '1, '1, '1);
    drain();

    // Random phases: sender idles lightly and receiver heavily, then swapped, then none.
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: configure(rand64(), (rand64() & ~64'd1) | 64'd1);
        1: configure(64'd0, 64'd0);
        2: configure('1, 64'd1);
        3: configure(rand64(), rand64() & ~64'd1);
        4: configure(64'(1000 + $urandom_range(1000)), 64'd1);
        default: configure('1, rand64() & ~64'd1);
      endcase
      if (p < 2) begin
        snd_idle = 14;
        rcv_idle = 47;
      end else if (p < 4) begin
        snd_idle = 47;
        rcv_idle = 14;
      end else begin
        snd_idle = 0;
        rcv_idle = 0;
      end
      // Hold the receiver off while items keep coming, so the input stalls.
      if (p == 5) hold_req = hold_req + 1;
      random_phase();
      drain();
    end

    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
